// File: hdl/lbsa_pkg.sv
// lbsa_pkg: constants, command codes and shared types of the section allocator
// used by lbsa_ctrl, lbsa_dpath and the top level; no dependencies
package lbsa_pkg;

    localparam int SLOT_COUNT      = 1024;
    localparam int SLOT_BYTES_LOG2 = 4;
    localparam int IDX_W           = $clog2(SLOT_COUNT);
    localparam int CNT_W           = IDX_W + 1;
    localparam int REQB_W          = 16;
    localparam int REQS_W          = REQB_W - SLOT_BYTES_LOG2 + 1;
    localparam int BYTES_W         = 14;
    localparam int BLK_W           = 10;
    localparam int STAT_W          = 2;
    localparam int SPLIT_SLOTS     = 3;

    localparam logic [IDX_W-1:0] GUARD_SLOT = IDX_W'(SLOT_COUNT - 1);

    // result status codes
    localparam logic [STAT_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd3;

    // slot flag bits {is_header, used}
    localparam logic [1:0] FLG_NONE     = 2'b00;
    localparam logic [1:0] FLG_FREE_HDR = 2'b10;
    localparam logic [1:0] FLG_USED_HDR = 2'b11;

    // datapath commands
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP          = 5'd0;
    localparam logic [OP_W-1:0] OP_CLR          = 5'd1;
    localparam logic [OP_W-1:0] OP_ACQ_START    = 5'd2;
    localparam logic [OP_W-1:0] OP_ACQ_CHECK    = 5'd3;
    localparam logic [OP_W-1:0] OP_ACQ_WR_NEW   = 5'd4;
    localparam logic [OP_W-1:0] OP_ACQ_WR_OWN   = 5'd5;
    localparam logic [OP_W-1:0] OP_REL_START    = 5'd6;
    localparam logic [OP_W-1:0] OP_REL_CHECK    = 5'd7;
    localparam logic [OP_W-1:0] OP_REL_RD_NEXT  = 5'd8;
    localparam logic [OP_W-1:0] OP_REL_CHK_NEXT = 5'd9;
    localparam logic [OP_W-1:0] OP_REL_RD_PREV  = 5'd10;
    localparam logic [OP_W-1:0] OP_REL_CHK_PREV = 5'd11;
    localparam logic [OP_W-1:0] OP_REL_WR_NEXT  = 5'd12;
    localparam logic [OP_W-1:0] OP_REL_WR_LINK  = 5'd13;
    localparam logic [OP_W-1:0] OP_SCAN_START   = 5'd14;
    localparam logic [OP_W-1:0] OP_SCAN_STEP    = 5'd15;
    localparam logic [OP_W-1:0] OP_OUT_LOAD     = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_ready;
    } lbsa_cmd_t;

    typedef struct packed {
        logic fail;
        logic split;
        logic scan_done;
        logic clr_last;
        logic is_release;
        logic out_free;
        logic req_pending;
    } lbsa_stat_t;

endpackage

// File: hdl/largest_block_section_allocator.sv
// largest_block_section_allocator: a refused item goes straight to the result hand-off; an
// acquire or a release then walks the chain of headers to find the largest free segment (at
// most about 511 headers), and the result may wait out an output stall, with a pass through
// the idle step before the next item; one item in work at a time.
// After reset a clearing pass writes the slot flags and links with in_ready low.
// top level: joins lbsa_ctrl and lbsa_dpath; depends on lbsa_pkg
module largest_block_section_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [lbsa_pkg::REQB_W-1:0]       req_bytes,
    input  logic [lbsa_pkg::BLK_W-1:0]        req_block,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lbsa_pkg::STAT_W-1:0]       status,
    output logic [lbsa_pkg::BLK_W-1:0]        grant_block,
    output logic [lbsa_pkg::BYTES_W-1:0]      grant_bytes,
    output logic [lbsa_pkg::BYTES_W-1:0]      largest_free_bytes
);

    // command from the sequencer, status back from the datapath
    lbsa_pkg::lbsa_cmd_t  cmd;
    lbsa_pkg::lbsa_stat_t st;

    // sequencer: clear pass, request steps, chain walk, result hand-off
    lbsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // memories, request registers, scan unit and output register
    lbsa_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .st                 (st),
        .in_valid           (in_valid),
        .req_type           (req_type),
        .req_bytes          (req_bytes),
        .req_block          (req_block),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .grant_block        (grant_block),
        .grant_bytes        (grant_bytes),
        .largest_free_bytes (largest_free_bytes)
    );

    // input is taken only in the idle step of the sequencer
    assign in_ready = cmd.in_ready;

endmodule

// File: hdl/lbsa_ctrl.sv
// lbsa_ctrl: sequencing state machine of the section allocator
// depends on lbsa_pkg
module lbsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbsa_pkg::lbsa_stat_t st,
    output lbsa_pkg::lbsa_cmd_t  cmd
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_ACQ0  = 5'd3;
    localparam logic [4:0] S_ACQ1  = 5'd4;
    localparam logic [4:0] S_ACQ2  = 5'd5;
    localparam logic [4:0] S_ACQ3  = 5'd6;
    localparam logic [4:0] S_REL0  = 5'd7;
    localparam logic [4:0] S_REL1  = 5'd8;
    localparam logic [4:0] S_REL2  = 5'd9;
    localparam logic [4:0] S_REL3  = 5'd10;
    localparam logic [4:0] S_REL4  = 5'd11;
    localparam logic [4:0] S_REL5  = 5'd12;
    localparam logic [4:0] S_REL6  = 5'd13;
    localparam logic [4:0] S_REL7  = 5'd14;
    localparam logic [4:0] S_SCAN0 = 5'd15;
    localparam logic [4:0] S_SCAN1 = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = lbsa_pkg::OP_NOP;
        cmd.in_ready = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.op = lbsa_pkg::OP_CLR;
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.req_pending) state_next = S_DISP;
            end
            S_DISP:
            begin
                state_next = st.is_release ? S_REL0 : S_ACQ0;
            end
            S_ACQ0:
            begin
                cmd.op     = lbsa_pkg::OP_ACQ_START;
                state_next = st.fail ? S_FIN : S_ACQ1;
            end
            S_ACQ1:
            begin
                cmd.op = lbsa_pkg::OP_ACQ_CHECK;
                if (st.fail) state_next = S_FIN;
                else state_next = st.split ? S_ACQ2 : S_ACQ3;
            end
            S_ACQ2:
            begin
                cmd.op     = lbsa_pkg::OP_ACQ_WR_NEW;
                state_next = S_ACQ3;
            end
            S_ACQ3:
            begin
                cmd.op     = lbsa_pkg::OP_ACQ_WR_OWN;
                state_next = S_SCAN0;
            end
            S_REL0:
            begin
                cmd.op     = lbsa_pkg::OP_REL_START;
                state_next = st.fail ? S_FIN : S_REL1;
            end
            S_REL1:
            begin
                cmd.op     = lbsa_pkg::OP_REL_CHECK;
                state_next = st.fail ? S_FIN : S_REL2;
            end
            S_REL2:
            begin
                cmd.op     = lbsa_pkg::OP_REL_RD_NEXT;
                state_next = S_REL3;
            end
            S_REL3:
            begin
                cmd.op     = lbsa_pkg::OP_REL_CHK_NEXT;
                state_next = st.fail ? S_FIN : S_REL4;
            end
            S_REL4:
            begin
                cmd.op     = lbsa_pkg::OP_REL_RD_PREV;
                state_next = S_REL5;
            end
            S_REL5:
            begin
                cmd.op     = lbsa_pkg::OP_REL_CHK_PREV;
                state_next = S_REL6;
            end
            S_REL6:
            begin
                cmd.op     = lbsa_pkg::OP_REL_WR_NEXT;
                state_next = S_REL7;
            end
            S_REL7:
            begin
                cmd.op     = lbsa_pkg::OP_REL_WR_LINK;
                state_next = S_SCAN0;
            end
            S_SCAN0:
            begin
                cmd.op     = lbsa_pkg::OP_SCAN_START;
                state_next = S_SCAN1;
            end
            S_SCAN1:
            begin
                cmd.op = lbsa_pkg::OP_SCAN_STEP;
                if (st.scan_done) state_next = S_FIN;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.op     = lbsa_pkg::OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

// File: hdl/lbsa_dpath.sv
// lbsa_dpath: link and flag memories, request registers, scan unit, result register
// depends on lbsa_pkg; driven by lbsa_ctrl commands
module lbsa_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lbsa_pkg::lbsa_cmd_t               cmd,
    output lbsa_pkg::lbsa_stat_t              st,
    input  logic                              in_valid,
    input  logic                              req_type,
    input  logic [lbsa_pkg::REQB_W-1:0]       req_bytes,
    input  logic [lbsa_pkg::BLK_W-1:0]        req_block,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lbsa_pkg::STAT_W-1:0]       status,
    output logic [lbsa_pkg::BLK_W-1:0]        grant_block,
    output logic [lbsa_pkg::BYTES_W-1:0]      grant_bytes,
    output logic [lbsa_pkg::BYTES_W-1:0]      largest_free_bytes
);

    localparam int IW = lbsa_pkg::IDX_W;
    localparam int RW = lbsa_pkg::REQS_W;
    localparam int BW = lbsa_pkg::BYTES_W;
    localparam int SH = lbsa_pkg::SLOT_BYTES_LOG2;
    localparam int REQB_W_EXT = lbsa_pkg::REQB_W + 1;

    // memories
    logic [IW-1:0] nxt_mem [lbsa_pkg::SLOT_COUNT];
    logic [IW-1:0] prv_mem [lbsa_pkg::SLOT_COUNT];
    logic [1:0]    flg_mem [lbsa_pkg::SLOT_COUNT];

    logic [IW-1:0] q_nxt;
    logic [IW-1:0] q_prv;
    logic [1:0]    q_flg;

    logic [IW-1:0] rd_addr;
    logic          nxt_we, prv_we, flg_we;
    logic [IW-1:0] nxt_wa, prv_wa, flg_wa;
    logic [IW-1:0] nxt_wd, prv_wd;
    logic [1:0]    flg_wd;

    // request and work registers
    logic                           take;
    logic                           type_reg;
    logic [lbsa_pkg::REQB_W-1:0]    bytes_reg;
    logic [lbsa_pkg::BLK_W-1:0]     blk_reg;
    logic [RW-1:0]                  req_reg;
    logic [IW-1:0]                  h_reg, p_reg, nx_reg, nn_reg, nb_reg;
    logic                           split_reg, mn_reg, mp_reg;
    logic [lbsa_pkg::STAT_W-1:0]    stat_reg;
    logic [lbsa_pkg::BLK_W-1:0]     gblock_reg;
    logic [BW-1:0]                  gbytes_reg;

    // scan registers
    logic [IW-1:0]                  best_reg, best_n_reg;
    logic                           found_reg;
    logic [lbsa_pkg::CNT_W-1:0]     steps_reg;

    // control registers
    logic [IW-1:0]                  clr_cnt_reg;
    logic [IW-1:0]                  largest_index_reg;
    logic                           largest_valid_reg;
    logic [BW-1:0]                  largest_bytes_reg;
    logic                           out_valid_reg;
    logic [lbsa_pkg::STAT_W-1:0]    out_stat_reg;
    logic [lbsa_pkg::BLK_W-1:0]     out_block_reg;
    logic [BW-1:0]                  out_gbytes_reg;
    logic [BW-1:0]                  out_largest_reg;

    // combinational terms
    logic [RW-1:0]  req_calc;
    logic [IW-1:0]  avail;
    logic           acq_fail, acq_split;
    logic [IW-1:0]  rel_h;
    logic           rel_start_fail, rel_check_fail, rel_next_fail;
    logic [IW-1:0]  nx_final, link_tgt;
    logic [IW-1:0]  scan_n;
    logic           scan_upd, scan_done;
    logic [IW-1:0]  best_pick, best_n_pick;
    logic           found_pick;

    assign take = cmd.in_ready && in_valid;

    always_comb
    begin
        req_calc = RW'(({1'b0, bytes_reg} + (REQB_W_EXT'(1) << SH) - REQB_W_EXT'(1)) >> SH);
        if (req_calc == '0) req_calc = RW'(1);
    end

    assign avail     = (q_nxt > h_reg) ? (q_nxt - h_reg - IW'(1)) : '0;
    assign acq_fail  = (h_reg >= lbsa_pkg::GUARD_SLOT) || !q_flg[1] || q_flg[0]
                       || (req_reg > RW'(avail));
    assign acq_split = ((RW + 1)'(avail) >= ((RW + 1)'(req_reg) + (RW + 1)'(lbsa_pkg::SPLIT_SLOTS - 1)));

    assign rel_h          = IW'(blk_reg) - IW'(1);
    assign rel_start_fail = (blk_reg == '0) || (IW'(blk_reg) > lbsa_pkg::GUARD_SLOT);
    assign rel_check_fail = (h_reg >= lbsa_pkg::GUARD_SLOT) || !q_flg[1] || !q_flg[0]
                            || (q_nxt <= h_reg) || (q_nxt > lbsa_pkg::GUARD_SLOT)
                            || ((h_reg != '0) && (q_prv >= h_reg));
    assign rel_next_fail  = !q_flg[0]
                            && ((q_nxt <= nx_reg) || (q_nxt > lbsa_pkg::GUARD_SLOT));
    assign nx_final       = mn_reg ? nn_reg : nx_reg;
    assign link_tgt       = mp_reg ? p_reg : h_reg;

    // one header of the chain per cycle
    assign scan_n      = (q_nxt > h_reg) ? (q_nxt - h_reg - IW'(1)) : '0;
    assign scan_upd    = !q_flg[0] && (!found_reg || (scan_n > best_n_reg));
    assign best_pick   = scan_upd ? h_reg : best_reg;
    assign best_n_pick = scan_upd ? scan_n : best_n_reg;
    assign found_pick  = found_reg || scan_upd;
    assign scan_done   = (q_nxt <= h_reg) || (q_nxt >= lbsa_pkg::GUARD_SLOT)
                         || (steps_reg == lbsa_pkg::CNT_W'(lbsa_pkg::SLOT_COUNT - 1));

    always_comb
    begin
        st.fail        = 1'b0;
        st.split       = acq_split;
        st.scan_done   = scan_done;
        st.clr_last    = (clr_cnt_reg == lbsa_pkg::GUARD_SLOT);
        st.is_release  = type_reg;
        st.out_free    = !out_valid_reg || out_ready;
        st.req_pending = in_valid;
        case (cmd.op)
            lbsa_pkg::OP_ACQ_START:    st.fail = !largest_valid_reg;
            lbsa_pkg::OP_ACQ_CHECK:    st.fail = acq_fail;
            lbsa_pkg::OP_REL_START:    st.fail = rel_start_fail;
            lbsa_pkg::OP_REL_CHECK:    st.fail = rel_check_fail;
            lbsa_pkg::OP_REL_CHK_NEXT: st.fail = rel_next_fail;
            default:                   st.fail = 1'b0;
        endcase
    end

    // read address select
    always_comb
    begin
        case (cmd.op)
            lbsa_pkg::OP_ACQ_START:   rd_addr = largest_index_reg;
            lbsa_pkg::OP_REL_START:   rd_addr = rel_h;
            lbsa_pkg::OP_REL_RD_NEXT: rd_addr = nx_reg;
            lbsa_pkg::OP_REL_RD_PREV: rd_addr = p_reg;
            lbsa_pkg::OP_SCAN_START:  rd_addr = '0;
            lbsa_pkg::OP_SCAN_STEP:   rd_addr = q_nxt;
            default:                  rd_addr = h_reg;
        endcase
    end

    // write port select
    always_comb
    begin
        nxt_we = 1'b0; nxt_wa = h_reg; nxt_wd = nx_final;
        prv_we = 1'b0; prv_wa = nx_final; prv_wd = h_reg;
        flg_we = 1'b0; flg_wa = h_reg; flg_wd = lbsa_pkg::FLG_NONE;
        case (cmd.op)
            lbsa_pkg::OP_CLR:
            begin
                nxt_we = 1'b1; nxt_wa = clr_cnt_reg;
                nxt_wd = (clr_cnt_reg == '0) ? lbsa_pkg::GUARD_SLOT : '0;
                prv_we = 1'b1; prv_wa = clr_cnt_reg; prv_wd = '0;
                flg_we = 1'b1; flg_wa = clr_cnt_reg;
                if (clr_cnt_reg == '0) flg_wd = lbsa_pkg::FLG_FREE_HDR;
                else if (clr_cnt_reg == lbsa_pkg::GUARD_SLOT) flg_wd = lbsa_pkg::FLG_USED_HDR;
                else flg_wd = lbsa_pkg::FLG_NONE;
            end
            lbsa_pkg::OP_ACQ_WR_NEW:
            begin
                nxt_we = 1'b1; nxt_wa = nb_reg; nxt_wd = nx_reg;
                prv_we = 1'b1; prv_wa = nb_reg; prv_wd = h_reg;
                flg_we = 1'b1; flg_wa = nb_reg; flg_wd = lbsa_pkg::FLG_FREE_HDR;
            end
            lbsa_pkg::OP_ACQ_WR_OWN:
            begin
                nxt_we = split_reg; nxt_wa = h_reg; nxt_wd = nb_reg;
                prv_we = split_reg; prv_wa = nx_reg; prv_wd = nb_reg;
                flg_we = 1'b1; flg_wa = h_reg; flg_wd = lbsa_pkg::FLG_USED_HDR;
            end
            lbsa_pkg::OP_REL_WR_NEXT:
            begin
                flg_we = mn_reg; flg_wa = nx_reg; flg_wd = lbsa_pkg::FLG_NONE;
            end
            lbsa_pkg::OP_REL_WR_LINK:
            begin
                nxt_we = 1'b1; nxt_wa = link_tgt; nxt_wd = nx_final;
                prv_we = 1'b1; prv_wa = nx_final; prv_wd = link_tgt;
                flg_we = 1'b1; flg_wa = h_reg;
                flg_wd = mp_reg ? lbsa_pkg::FLG_NONE : lbsa_pkg::FLG_FREE_HDR;
            end
            default:
            begin
                nxt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        q_nxt <= nxt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we) prv_mem[prv_wa] <= prv_wd;
        q_prv <= prv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flg_we) flg_mem[flg_wa] <= flg_wd;
        q_flg <= flg_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            type_reg   <= req_type;
            bytes_reg  <= req_bytes;
            blk_reg    <= req_block;
            stat_reg   <= lbsa_pkg::ST_GRANTED;
            gblock_reg <= '0;
            gbytes_reg <= '0;
        end
        case (cmd.op)
            lbsa_pkg::OP_ACQ_START:
            begin
                req_reg <= req_calc;
                h_reg   <= largest_index_reg;
                if (!largest_valid_reg) stat_reg <= lbsa_pkg::ST_NO_SPACE;
            end
            lbsa_pkg::OP_ACQ_CHECK:
            begin
                nx_reg    <= q_nxt;
                nb_reg    <= h_reg + IW'(req_reg) + IW'(1);
                split_reg <= acq_split;
                if (acq_fail)
                begin
                    stat_reg <= lbsa_pkg::ST_NO_SPACE;
                end
                else
                begin
                    gblock_reg <= lbsa_pkg::BLK_W'(h_reg + IW'(1));
                    gbytes_reg <= acq_split ? BW'({req_reg, {SH{1'b0}}})
                                            : BW'({avail, {SH{1'b0}}});
                end
            end
            lbsa_pkg::OP_REL_START:
            begin
                h_reg <= rel_h;
                if (rel_start_fail) stat_reg <= lbsa_pkg::ST_INVALID;
            end
            lbsa_pkg::OP_REL_CHECK:
            begin
                nx_reg <= q_nxt;
                p_reg  <= q_prv;
                if (rel_check_fail) stat_reg <= lbsa_pkg::ST_INVALID;
            end
            lbsa_pkg::OP_REL_CHK_NEXT:
            begin
                mn_reg <= !q_flg[0];
                nn_reg <= q_nxt;
                if (rel_next_fail) stat_reg <= lbsa_pkg::ST_INVALID;
            end
            lbsa_pkg::OP_REL_CHK_PREV:
            begin
                mp_reg <= (h_reg != '0) && !q_flg[0];
            end
            lbsa_pkg::OP_REL_WR_LINK:
            begin
                stat_reg <= lbsa_pkg::ST_RELEASED;
            end
            lbsa_pkg::OP_SCAN_START:
            begin
                h_reg      <= '0;
                best_reg   <= '0;
                best_n_reg <= '0;
                found_reg  <= 1'b0;
                steps_reg  <= '0;
            end
            lbsa_pkg::OP_SCAN_STEP:
            begin
                best_reg   <= best_pick;
                best_n_reg <= best_n_pick;
                found_reg  <= found_pick;
                h_reg      <= q_nxt;
                steps_reg  <= steps_reg + lbsa_pkg::CNT_W'(1);
            end
            lbsa_pkg::OP_OUT_LOAD:
            begin
                out_stat_reg    <= stat_reg;
                out_block_reg   <= gblock_reg;
                out_gbytes_reg  <= gbytes_reg;
                out_largest_reg <= largest_bytes_reg;
            end
            default:
            begin
                h_reg <= h_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg       <= '0;
            largest_index_reg <= '0;
            largest_valid_reg <= 1'b1;
            largest_bytes_reg <= BW'((lbsa_pkg::SLOT_COUNT - 2) << SH);
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.op == lbsa_pkg::OP_CLR) clr_cnt_reg <= clr_cnt_reg + IW'(1);
            if ((cmd.op == lbsa_pkg::OP_SCAN_STEP) && scan_done)
            begin
                largest_valid_reg <= found_pick;
                largest_index_reg <= found_pick ? best_pick : '0;
                largest_bytes_reg <= found_pick ? BW'({best_n_pick, {SH{1'b0}}}) : '0;
            end
            if (cmd.op == lbsa_pkg::OP_OUT_LOAD) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_stat_reg;
    assign grant_block        = out_block_reg;
    assign grant_bytes        = out_gbytes_reg;
    assign largest_free_bytes = out_largest_reg;

    a_no_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stat_reg != lbsa_pkg::ST_GRANTED))
        |-> ((out_block_reg == '0) && (out_gbytes_reg == '0)))
        else $error("grant fields set on a non-grant result");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stat_reg == lbsa_pkg::ST_GRANTED))
        |-> ((out_gbytes_reg != '0) && (out_block_reg != '0)))
        else $error("grant without blocks");

    a_empty_largest: assert property (@(posedge clk) disable iff (!rst_n)
        !largest_valid_reg |-> (largest_bytes_reg == '0))
        else $error("largest size without a free segment");

    a_split_above: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lbsa_pkg::OP_ACQ_WR_NEW) |-> (split_reg && (nb_reg > h_reg)
        && (nb_reg < nx_reg)))
        else $error("split header outside its segment");

endmodule
